// ----- src/tpsw_pkg.sv -----
// Package for the three-phase sag waveform PWM block: codes, result type and the
// elaboration-time sine table function. No dependencies.
`default_nettype none

package tpsw_pkg;

  // Item operation codes
  localparam logic [2:0] OP_PERIOD   = 3'd0;
  localparam logic [2:0] OP_MS       = 3'd1;
  localparam logic [2:0] OP_SAG      = 3'd2;
  localparam logic [2:0] OP_PATTERN  = 3'd3;
  localparam logic [2:0] OP_STOP_SAG = 3'd4;
  localparam logic [2:0] OP_STOP_PAT = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NESTED_SAG  = 3'd1;
  localparam logic [2:0] ST_PAT_ACTIVE  = 3'd2;
  localparam logic [2:0] ST_SAG_ACTIVE  = 3'd3;
  localparam logic [2:0] ST_STOP_NA     = 3'd4;

  // Channel modes
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_SAG     = 2'd1;
  localparam logic [1:0] MODE_PATTERN = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DUTY_MIN    = 3'd0;
  localparam logic [2:0] CFG_DUTY_MAX    = 3'd1;
  localparam logic [2:0] CFG_DUTY_OFFSET = 3'd2;
  localparam logic [2:0] CFG_NORMAL_AMP  = 3'd3;

  // Configuration reset values
  localparam logic [15:0] RST_DUTY_MIN    = 16'd0;
  localparam logic [15:0] RST_DUTY_MAX    = 16'd1679;
  localparam logic [15:0] RST_DUTY_OFFSET = 16'd839;
  localparam logic [15:0] RST_NORMAL_AMP  = 16'd839;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  status;
    logic [1:0]  channel_mode;
  } rsp_t;

  // Shift-subtract divide, used only while building constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= d) begin
        r    = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Bhaskara sine sample in Q15 for sample i of channel c (phase c/3 of a turn)
  function automatic logic signed [15:0] sine_q15(input int samples, input int i,
                                                  input int c);
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] t64;
    logic [31:0] t;
    logic [63:0] u;
    logic [63:0] p;
    logic [63:0] m;
    den = 64'(3 * samples);
    num = 64'(3 * i + c * samples);
    if (num >= den) begin
      num = num - den;
    end
    t64 = udiv64(num << 32, den);
    t   = t64[31:0];
    u   = 64'(t[30:15]);
    p   = u * (64'd65536 - u);
    m   = udiv64(64'd16 * p * 64'd32767, 64'd5 * 64'h1_0000_0000 - 64'd4 * p);
    return t[31] ? -$signed(16'(m)) : $signed(16'(m));
  endfunction

endpackage

`default_nettype wire

// ----- src/tpsw_req_if.sv -----
// Request channel interface: valid/ready handshake and one request item.
// No dependencies.
`default_nettype none

interface tpsw_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        load_entry;
  logic [1:0]  channel;
  logic [15:0] amplitude;
  logic [15:0] duration;
  logic [2:0]  pattern_index;
  logic [3:0]  pattern_count;

  modport source (output valid, op, load_entry, channel, amplitude, duration,
                  pattern_index, pattern_count, input ready);
  modport sink   (input valid, op, load_entry, channel, amplitude, duration,
                  pattern_index, pattern_count, output ready);
endinterface

`default_nettype wire

// ----- src/tpsw_rsp_if.sv -----
// Result channel interface: valid/ready handshake and one result item.
// No dependencies.
`default_nettype none

interface tpsw_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic [15:0] duty_c;
  logic [2:0]  status;
  logic [1:0]  channel_mode;

  modport source (output valid, duty_a, duty_b, duty_c, status, channel_mode,
                  input ready);
  modport sink   (input valid, duty_a, duty_b, duty_c, status, channel_mode,
                  output ready);
endinterface

`default_nettype wire

// ----- src/tpsw_cfg_if.sv -----
// Configuration write channel interface: valid/ready, register index and data.
// No dependencies.
`default_nettype none

interface tpsw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/tpsw_ram.sv -----
// Generic single-port-write RAM with one registered read port, write-first on a
// same-address collision. No dependencies.
`default_nettype none

module tpsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the new word when it is written in the same cycle
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/three_phase_sag_waveform_pwm_top.sv -----
// Top level of the three-phase sag waveform PWM duty generator.
// Depends on tpsw_pkg, tpsw_req_if, tpsw_rsp_if, tpsw_cfg_if and tpsw_ram.
//
//   port  | dir  | moves
//   ------+------+----------------------------------------------------------
//   req   | sink | one request item (tick, sag or pattern op) per handshake
//   rsp   | src  | one result item (three duties, status, mode) per request
//   cfg   | sink | one register write (duty_min/max/offset, normal amplitude)
//
// One item per cycle while the result queue has room; an accepted item's result is
// registered into the queue and offered once earlier results are taken. Sine samples
// and pattern entries sit in registered read stores addressed with the next state, so
// they always match the present state. A two-entry result queue keeps req ready while
// one result waits on a stalled rsp. Reset (rst, synchronous) restores registers and
// channel state. Pattern entries hold no reset value.
`default_nettype none

module three_phase_sag_waveform_pwm_top
  import tpsw_pkg::*;
#(
  parameter int SAMPLES         = 1000,
  parameter int PATTERN_ENTRIES = 8
) (
  input wire logic clk,
  input wire logic rst,
  tpsw_req_if.sink   req,
  tpsw_rsp_if.source rsp,
  tpsw_cfg_if.sink   cfg
);

  localparam int SW = $clog2(SAMPLES);
  localparam int EW = (PATTERN_ENTRIES > 1) ? $clog2(PATTERN_ENTRIES) : 1;
  localparam int UW = $clog2(PATTERN_ENTRIES + 1);

  typedef logic signed [15:0] sin_tbl_t [SAMPLES];
  typedef logic [EW-1:0] idx_map_t [8];

  function automatic sin_tbl_t build_sin(input int c);
    sin_tbl_t t;
    for (int i = 0; i < SAMPLES; i++) begin
      t[i] = sine_q15(SAMPLES, i, c);
    end
    return t;
  endfunction

  function automatic idx_map_t build_idx_map();
    idx_map_t m;
    for (int k = 0; k < 8; k++) begin
      m[k] = EW'(k % PATTERN_ENTRIES);
    end
    return m;
  endfunction

  localparam idx_map_t IDX_MAP = build_idx_map();

  // Configuration registers
  logic [15:0] duty_min;
  logic [15:0] duty_max;
  logic [15:0] duty_offset;
  logic [15:0] normal_amp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_min    <= RST_DUTY_MIN;
      duty_max    <= RST_DUTY_MAX;
      duty_offset <= RST_DUTY_OFFSET;
      normal_amp  <= RST_NORMAL_AMP;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DUTY_MIN:    duty_min    <= cfg.data;
        CFG_DUTY_MAX:    duty_max    <= cfg.data;
        CFG_DUTY_OFFSET: duty_offset <= cfg.data;
        CFG_NORMAL_AMP:  normal_amp  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Channel state
  logic [SW-1:0] sample_index;
  logic [SW-1:0] sample_index_next;
  logic [1:0]    mode [3];
  logic [1:0]    mode_next [3];
  logic [15:0]   sag_amp [3];
  logic [15:0]   sag_amp_next [3];
  logic [15:0]   sag_rem [3];
  logic [15:0]   sag_rem_next [3];
  logic [EW-1:0] cur_entry [3];
  logic [EW-1:0] cur_entry_next [3];
  logic [15:0]   elapsed [3];
  logic [15:0]   elapsed_next [3];
  logic [UW-1:0] used [3];
  logic [UW-1:0] used_next [3];

  // Registered store outputs, always matching present state
  logic signed [15:0] sin_q [3];
  logic [31:0]        ent_q [3];

  logic          accept;
  logic [EW-1:0] req_idx;
  logic [UW-1:0] cnt_sat;
  logic [UW-1:0] cur_plus [3];
  logic [2:0]    status;
  logic [1:0]    ch_mode;
  logic [15:0]   duty [3];
  rsp_t          result;

  // Result queue
  rsp_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       pop;

  assign accept  = req.valid && req.ready;
  assign req_idx = IDX_MAP[req.pattern_index];

  // Pattern count clamped into 1..PATTERN_ENTRIES
  always_comb begin
    if (req.pattern_count == 4'd0) begin
      cnt_sat = UW'(1);
    end else if (int'(req.pattern_count) > PATTERN_ENTRIES) begin
      cnt_sat = UW'(PATTERN_ENTRIES);
    end else begin
      cnt_sat = UW'(req.pattern_count);
    end
  end

  // Next state and status for the accepted item
  always_comb begin
    sample_index_next = sample_index;
    status            = ST_OK;
    for (int c = 0; c < 3; c++) begin
      mode_next[c]      = mode[c];
      sag_amp_next[c]   = sag_amp[c];
      sag_rem_next[c]   = sag_rem[c];
      cur_entry_next[c] = cur_entry[c];
      elapsed_next[c]   = elapsed[c];
      used_next[c]      = used[c];
      cur_plus[c]       = UW'(cur_entry[c]) + UW'(1);
    end
    if (accept) begin
      case (req.op)
        OP_PERIOD: begin
          sample_index_next = (sample_index == SW'(SAMPLES - 1)) ? '0
                                                                 : sample_index + SW'(1);
        end
        OP_MS: begin
          for (int c = 0; c < 3; c++) begin
            if (mode[c] == MODE_SAG) begin
              if (sag_rem[c] != 16'd0) begin
                sag_rem_next[c] = sag_rem[c] - 16'd1;
              end else begin
                mode_next[c] = MODE_NORMAL;
              end
            end else if (mode[c] == MODE_PATTERN) begin
              if (elapsed[c] < ent_q[c][15:0]) begin
                elapsed_next[c] = elapsed[c] + 16'd1;
              end else begin
                cur_entry_next[c] = (cur_plus[c] < used[c]) ? EW'(cur_plus[c]) : '0;
                elapsed_next[c]   = '0;
              end
            end
          end
        end
        OP_SAG, OP_PATTERN, OP_STOP_SAG, OP_STOP_PAT: begin
          if (req.channel == 2'd3) begin
            status = ST_STOP_NA;
          end
          for (int c = 0; c < 3; c++) begin
            if (req.channel == 2'(c)) begin
              case (req.op)
                OP_SAG: begin
                  if (mode[c] == MODE_SAG) begin
                    status = ST_NESTED_SAG;
                  end else if (mode[c] == MODE_PATTERN) begin
                    status = ST_PAT_ACTIVE;
                  end else begin
                    mode_next[c]    = MODE_SAG;
                    sag_amp_next[c] = req.amplitude;
                    sag_rem_next[c] = req.duration;
                  end
                end
                OP_PATTERN: begin
                  if (req.load_entry) begin
                    status = ST_OK;
                  end else if (mode[c] == MODE_SAG) begin
                    status = ST_SAG_ACTIVE;
                  end else begin
                    mode_next[c]      = MODE_PATTERN;
                    cur_entry_next[c] = req_idx;
                    used_next[c]      = cnt_sat;
                    elapsed_next[c]   = '0;
                  end
                end
                OP_STOP_SAG: begin
                  if (mode[c] == MODE_SAG) begin
                    mode_next[c] = MODE_NORMAL;
                  end else begin
                    status = ST_STOP_NA;
                  end
                end
                default: begin
                  if (mode[c] == MODE_PATTERN) begin
                    mode_next[c] = MODE_NORMAL;
                  end else begin
                    status = ST_STOP_NA;
                  end
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      for (int c = 0; c < 3; c++) begin
        mode[c]      <= MODE_NORMAL;
        sag_amp[c]   <= '0;
        sag_rem[c]   <= '0;
        cur_entry[c] <= '0;
        elapsed[c]   <= '0;
        used[c]      <= UW'(1);
      end
    end else begin
      sample_index <= sample_index_next;
      for (int c = 0; c < 3; c++) begin
        mode[c]      <= mode_next[c];
        sag_amp[c]   <= sag_amp_next[c];
        sag_rem[c]   <= sag_rem_next[c];
        cur_entry[c] <= cur_entry_next[c];
        elapsed[c]   <= elapsed_next[c];
        used[c]      <= used_next[c];
      end
    end
  end

  // Per-channel sine table and pattern store, read at the next state's address
  for (genvar g = 0; g < 3; g++) begin : g_ch
    localparam sin_tbl_t SIN_TBL = build_sin(g);

    logic [SW-1:0] sin_addr;
    logic [EW-1:0] ent_addr;
    logic          ent_we;

    assign sin_addr = rst ? '0 : sample_index_next;
    assign ent_addr = rst ? '0 : cur_entry_next[g];
    assign ent_we   = accept && (req.op == OP_PATTERN) && req.load_entry &&
                      (req.channel == 2'(g));

    always_ff @(posedge clk) begin
      sin_q[g] <= SIN_TBL[sin_addr];
    end

    tpsw_ram #(
      .WIDTH (32),
      .DEPTH (PATTERN_ENTRIES)
    ) u_pat_ram (
      .clk   (clk),
      .we    (ent_we),
      .waddr (req_idx),
      .wdata ({req.amplitude, req.duration}),
      .raddr (ent_addr),
      .rdata (ent_q[g])
    );

    // Duty: clamp(amp * sin + offset, min, max)
    logic [15:0]        amp;
    logic signed [32:0] prod;
    logic signed [33:0] total;
    logic [17:0]        v;

    always_comb begin
      case (mode[g])
        MODE_SAG:     amp = sag_amp[g];
        MODE_PATTERN: amp = ent_q[g][31:16];
        default:      amp = normal_amp;
      endcase
      prod  = $signed({1'b0, amp}) * sin_q[g];
      total = $signed({3'b000, duty_offset, 15'd0}) + 34'(prod);
      v     = total[32:15];
      if (total[33] || (v < {2'b00, duty_min})) begin
        duty[g] = duty_min;
      end else if (v > {2'b00, duty_max}) begin
        duty[g] = duty_max;
      end else begin
        duty[g] = v[15:0];
      end
    end
  end

  // Addressed channel mode after the step
  always_comb begin
    case (req.channel)
      2'd0:    ch_mode = mode_next[0];
      2'd1:    ch_mode = mode_next[1];
      2'd2:    ch_mode = mode_next[2];
      default: ch_mode = MODE_NORMAL;
    endcase
  end

  always_comb begin
    result.duty_a       = (req.op == OP_PERIOD) ? duty[0] : 16'd0;
    result.duty_b       = (req.op == OP_PERIOD) ? duty[1] : 16'd0;
    result.duty_c       = (req.op == OP_PERIOD) ? duty[2] : 16'd0;
    result.status       = status;
    result.channel_mode = ch_mode;
  end

  // Two-entry result queue
  assign req.ready = (fill != 2'd2);
  assign rsp.valid = (fill != 2'd0);
  assign pop       = rsp.valid && rsp.ready;

  assign rsp.duty_a       = slot[rd_ptr].duty_a;
  assign rsp.duty_b       = slot[rd_ptr].duty_b;
  assign rsp.duty_c       = slot[rd_ptr].duty_c;
  assign rsp.status       = slot[rd_ptr].status;
  assign rsp.channel_mode = slot[rd_ptr].channel_mode;

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, accept} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire
